/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* hdl/shp_pkg.sv */
package shp_pkg;

    // default parameter values
    localparam int POSITION_BITS_DEF    = 31;
    localparam int ARRIVE_TOLERANCE_DEF = 50;

    // configuration register indexes
    localparam logic [3:0] CFG_SEEK_NEGATIVE     = 4'd0;
    localparam logic [3:0] CFG_SENSOR_ACTIVE_LOW = 4'd1;
    localparam logic [3:0] CFG_FAST_SPEED        = 4'd2;
    localparam logic [3:0] CFG_SLOW_SPEED        = 4'd3;
    localparam logic [3:0] CFG_SEARCH_LIMIT      = 4'd4;
    localparam logic [3:0] CFG_BACKOFF_DISTANCE  = 4'd5;
    localparam logic [3:0] CFG_REST_OFFSET       = 4'd6;
    localparam logic [3:0] CFG_TIMEOUT_MS        = 4'd7;

    // configuration reset values
    localparam logic [19:0] FAST_SPEED_RST       = 20'd20000;
    localparam logic [19:0] SLOW_SPEED_RST       = 20'd2000;
    localparam logic [29:0] SEARCH_LIMIT_RST     = 30'd300000;
    localparam logic [23:0] BACKOFF_DISTANCE_RST = 24'd3000;
    localparam logic [23:0] REST_OFFSET_RST      = 24'd1000;
    localparam logic [31:0] TIMEOUT_MS_RST       = 32'd30000;

    // command kinds
    localparam logic [1:0] KIND_STOP     = 2'd0;
    localparam logic [1:0] KIND_VELOCITY = 2'd1;
    localparam logic [1:0] KIND_MOVE_TO  = 2'd2;

    // fault codes
    localparam logic [2:0] FAULT_NONE         = 3'd0;
    localparam logic [2:0] FAULT_SENSOR_START = 3'd1;
    localparam logic [2:0] FAULT_TIMEOUT      = 3'd2;
    localparam logic [2:0] FAULT_OVERTRAVEL   = 3'd3;
    localparam logic [2:0] FAULT_NOT_RELEASED = 3'd4;
    localparam logic [2:0] FAULT_NEVER_REACHED = 3'd5;

    // phase codes seen outside the sequencer
    localparam logic [3:0] PHASE_CHECK = 4'd1;
    localparam logic [3:0] PHASE_FAULT = 4'd10;

    // opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_START  = 1'b1;

    typedef struct packed {
        logic        seek_negative;
        logic        sensor_active_low;
        logic [19:0] fast_speed;
        logic [19:0] slow_speed;
        logic [29:0] search_limit;
        logic [23:0] backoff_distance;
        logic [23:0] rest_offset;
        logic [31:0] timeout_ms;
    } t_cfg;

endpackage

/* hdl/shp_cfg_regs.sv */
module shp_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output shp_pkg::t_cfg      o_cfg
);

    shp_pkg::t_cfg r_cfg;
    shp_pkg::t_cfg n_cfg;

    // decode a write transfer, unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && i_cfg_ready) begin
            unique case (i_cfg_index)
                shp_pkg::CFG_SEEK_NEGATIVE:     n_cfg.seek_negative     = i_cfg_data[0];
                shp_pkg::CFG_SENSOR_ACTIVE_LOW: n_cfg.sensor_active_low = i_cfg_data[0];
                shp_pkg::CFG_FAST_SPEED:        n_cfg.fast_speed        = i_cfg_data[19:0];
                shp_pkg::CFG_SLOW_SPEED:        n_cfg.slow_speed        = i_cfg_data[19:0];
                shp_pkg::CFG_SEARCH_LIMIT:      n_cfg.search_limit      = i_cfg_data[29:0];
                shp_pkg::CFG_BACKOFF_DISTANCE:  n_cfg.backoff_distance  = i_cfg_data[23:0];
                shp_pkg::CFG_REST_OFFSET:       n_cfg.rest_offset       = i_cfg_data[23:0];
                shp_pkg::CFG_TIMEOUT_MS:        n_cfg.timeout_ms        = i_cfg_data;
                default: ;
            endcase
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seek_negative     <= 1'b0;
            r_cfg.sensor_active_low <= 1'b0;
            r_cfg.fast_speed        <= shp_pkg::FAST_SPEED_RST;
            r_cfg.slow_speed        <= shp_pkg::SLOW_SPEED_RST;
            r_cfg.search_limit      <= shp_pkg::SEARCH_LIMIT_RST;
            r_cfg.backoff_distance  <= shp_pkg::BACKOFF_DISTANCE_RST;
            r_cfg.rest_offset       <= shp_pkg::REST_OFFSET_RST;
            r_cfg.timeout_ms        <= shp_pkg::TIMEOUT_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/shp_seq.sv */
module shp_seq #(
    parameter int POSITION_BITS    = shp_pkg::POSITION_BITS_DEF,
    parameter int ARRIVE_TOLERANCE = shp_pkg::ARRIVE_TOLERANCE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  shp_pkg::t_cfg                   i_cfg,
    input  logic                            i_opcode,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_raw_sensor,
    input  logic signed [POSITION_BITS-1:0] i_position,
    input  logic                            i_moving,
    output logic [1:0]                      o_move_kind,
    output logic signed [20:0]              o_velocity,
    output logic signed [31:0]              o_target,
    output logic [3:0]                      o_phase,
    output logic [2:0]                      o_fault_code
);

    // wide enough for position differences, targets and the search limit
    localparam int W = ((POSITION_BITS > 30) ? POSITION_BITS : 30) + 3;
    localparam logic signed [W-1:0] TOL = W'(ARRIVE_TOLERANCE);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_CHECK      = shp_pkg::PHASE_CHECK,
        PH_SEEK_FAST  = 4'd2,
        PH_BRAKE_FAST = 4'd3,
        PH_BACKOFF    = 4'd4,
        PH_SEEK_SLOW  = 4'd5,
        PH_BRAKE_SLOW = 4'd6,
        PH_SET_ZERO   = 4'd7,
        PH_TO_OFFSET  = 4'd8,
        PH_READY      = 4'd9,
        PH_FAULT      = shp_pkg::PHASE_FAULT
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [2:0]                 r_fault, n_fault;
    logic [31:0]                r_start_time, n_start_time;
    logic signed [W-1:0]        r_start_pos, n_start_pos;
    logic signed [W-1:0]        r_first_trig, n_first_trig;
    logic signed [W-1:0]        r_second_trig, n_second_trig;
    logic signed [W-1:0]        r_backoff_tgt, n_backoff_tgt;
    logic signed [W-1:0]        r_rest_tgt, n_rest_tgt;
    logic [1:0]                 r_kind, n_kind;
    logic signed [20:0]         r_vel, n_vel;
    logic signed [W-1:0]        r_tgt, n_tgt;

    logic                       w_sensor;
    logic [31:0]                w_elapsed;
    logic                       w_timed_out;
    logic signed [W-1:0]        w_pos;
    logic signed [W-1:0]        w_travel, w_travel_abs;
    logic signed [W-1:0]        w_limit;
    logic                       w_over;
    logic signed [W-1:0]        w_back_err, w_back_abs;
    logic signed [W-1:0]        w_rest_err, w_rest_abs;
    logic                       w_at_backoff, w_at_rest;
    logic signed [W-1:0]        w_backoff_step, w_rest_step;
    logic signed [20:0]         w_fast_vel, w_slow_vel;

    // conditions of this tick
    always_comb begin
        w_sensor     = i_raw_sensor ^ i_cfg.sensor_active_low;
        w_elapsed    = i_now_ms - r_start_time;
        w_timed_out  = w_elapsed > i_cfg.timeout_ms;
        w_pos        = {{(W-POSITION_BITS){i_position[POSITION_BITS-1]}}, i_position};
        w_travel     = w_pos - r_start_pos;
        w_travel_abs = w_travel[W-1] ? -w_travel : w_travel;
        w_limit      = {{(W-30){1'b0}}, i_cfg.search_limit};
        w_over       = w_travel_abs > w_limit;
        w_back_err   = w_pos - r_backoff_tgt;
        w_back_abs   = w_back_err[W-1] ? -w_back_err : w_back_err;
        w_at_backoff = w_back_abs < TOL;
        w_rest_err   = w_pos - r_rest_tgt;
        w_rest_abs   = w_rest_err[W-1] ? -w_rest_err : w_rest_err;
        w_at_rest    = w_rest_abs < TOL;
    end

    // direction-dependent speeds and retreat steps
    always_comb begin
        if (i_cfg.seek_negative) begin
            w_fast_vel     = -$signed({1'b0, i_cfg.fast_speed});
            w_slow_vel     = -$signed({1'b0, i_cfg.slow_speed});
            w_backoff_step = {{(W-24){1'b0}}, i_cfg.backoff_distance};
            w_rest_step    = {{(W-24){1'b0}}, i_cfg.rest_offset};
        end else begin
            w_fast_vel     = $signed({1'b0, i_cfg.fast_speed});
            w_slow_vel     = $signed({1'b0, i_cfg.slow_speed});
            w_backoff_step = -$signed({{(W-24){1'b0}}, i_cfg.backoff_distance});
            w_rest_step    = -$signed({{(W-24){1'b0}}, i_cfg.rest_offset});
        end
    end

    // sequence step
    always_comb begin
        n_phase       = r_phase;
        n_fault       = r_fault;
        n_start_time  = r_start_time;
        n_start_pos   = r_start_pos;
        n_first_trig  = r_first_trig;
        n_second_trig = r_second_trig;
        n_backoff_tgt = r_backoff_tgt;
        n_rest_tgt    = r_rest_tgt;
        n_kind        = shp_pkg::KIND_STOP;
        n_vel         = '0;
        n_tgt         = '0;
        if (i_opcode == shp_pkg::OP_START) begin
            n_phase      = PH_CHECK;
            n_fault      = shp_pkg::FAULT_NONE;
            n_start_time = i_now_ms;
            n_start_pos  = '0;
        end else begin
            unique case (r_phase)
                PH_CHECK: begin
                    n_start_pos = w_pos;
                    if (w_sensor) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_SENSOR_START;
                    end else begin
                        n_phase = PH_SEEK_FAST;
                        n_kind  = shp_pkg::KIND_VELOCITY;
                        n_vel   = w_fast_vel;
                    end
                end
                PH_SEEK_FAST: begin
                    priority if (w_timed_out) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_TIMEOUT;
                    end else if (w_over) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_OVERTRAVEL;
                    end else if (w_sensor) begin
                        n_first_trig = w_pos;
                        n_phase      = PH_BRAKE_FAST;
                    end else begin
                        n_kind = shp_pkg::KIND_VELOCITY;
                        n_vel  = w_fast_vel;
                    end
                end
                PH_BRAKE_FAST: begin
                    priority if (w_timed_out) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_TIMEOUT;
                    end else if (!i_moving) begin
                        n_backoff_tgt = r_first_trig + w_backoff_step;
                        n_phase       = PH_BACKOFF;
                        n_kind        = shp_pkg::KIND_MOVE_TO;
                        n_tgt         = r_first_trig + w_backoff_step;
                    end else begin
                    end
                end
                PH_BACKOFF: begin
                    priority if (w_timed_out) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_TIMEOUT;
                    end else if (w_at_backoff && w_sensor) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_NOT_RELEASED;
                    end else if (w_at_backoff) begin
                        n_phase = PH_SEEK_SLOW;
                        n_kind  = shp_pkg::KIND_VELOCITY;
                        n_vel   = w_slow_vel;
                    end else begin
                        n_kind = shp_pkg::KIND_MOVE_TO;
                        n_tgt  = r_backoff_tgt;
                    end
                end
                PH_SEEK_SLOW: begin
                    priority if (w_timed_out) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_TIMEOUT;
                    end else if (w_over) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_NEVER_REACHED;
                    end else if (w_sensor) begin
                        n_second_trig = w_pos;
                        n_phase       = PH_BRAKE_SLOW;
                    end else begin
                        n_kind = shp_pkg::KIND_VELOCITY;
                        n_vel  = w_slow_vel;
                    end
                end
                PH_BRAKE_SLOW: begin
                    priority if (w_timed_out) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_TIMEOUT;
                    end else if (!i_moving) begin
                        n_phase = PH_SET_ZERO;
                    end else begin
                    end
                end
                PH_SET_ZERO: begin
                    n_rest_tgt = r_second_trig + w_rest_step;
                    n_phase    = PH_TO_OFFSET;
                    n_kind     = shp_pkg::KIND_MOVE_TO;
                    n_tgt      = r_second_trig + w_rest_step;
                end
                PH_TO_OFFSET: begin
                    priority if (w_timed_out) begin
                        n_phase = PH_FAULT;
                        n_fault = shp_pkg::FAULT_TIMEOUT;
                    end else if (w_at_rest) begin
                        n_phase = PH_READY;
                    end else begin
                        n_kind = shp_pkg::KIND_MOVE_TO;
                        n_tgt  = r_rest_tgt;
                    end
                end
                // idle, ready, fault and unused codes hold and answer stop
                default: ;
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_fault       <= shp_pkg::FAULT_NONE;
            r_start_time  <= '0;
            r_start_pos   <= '0;
            r_first_trig  <= '0;
            r_second_trig <= '0;
            r_backoff_tgt <= '0;
            r_rest_tgt    <= '0;
            r_kind        <= shp_pkg::KIND_STOP;
            r_vel         <= '0;
            r_tgt         <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_fault       <= n_fault;
            r_start_time  <= n_start_time;
            r_start_pos   <= n_start_pos;
            r_first_trig  <= n_first_trig;
            r_second_trig <= n_second_trig;
            r_backoff_tgt <= n_backoff_tgt;
            r_rest_tgt    <= n_rest_tgt;
            r_kind        <= n_kind;
            r_vel         <= n_vel;
            r_tgt         <= n_tgt;
        end
    end

    assign o_move_kind  = r_kind;
    assign o_velocity   = r_vel;
    assign o_target     = r_tgt[31:0];
    assign o_phase      = r_phase;
    assign o_fault_code = r_fault;

endmodule

/* hdl/stepper_homing_sequencer_top.sv */
// Two-pass axis homing sequencer. Each accepted control tick yields exactly one
// command (stop, velocity or move-to) with the phase after the tick and a fault
// code. Ticks are taken one per clock while the result side does not stall; a
// tick is captured in the input register and its result is then registered in
// the output register once the result slot is free or being emptied. A stall on
// the result side holds the input register and backs up into o_in_stall in the
// same cycle. Configuration writes are always ready and take effect on the next
// edge; write them only while no tick is in flight.
`include "assert_macros.svh"

module stepper_homing_sequencer_top #(
    parameter int POSITION_BITS    = shp_pkg::POSITION_BITS_DEF,
    parameter int ARRIVE_TOLERANCE = shp_pkg::ARRIVE_TOLERANCE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [3:0]                      i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    // tick input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_raw_sensor,
    input  logic signed [POSITION_BITS-1:0] i_position,
    input  logic                            i_moving,
    // command output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_move_kind,
    output logic signed [20:0]              o_velocity,
    output logic signed [31:0]              o_target,
    output logic [3:0]                      o_phase,
    output logic [2:0]                      o_fault_code
);

    shp_pkg::t_cfg                  w_cfg;
    logic                           r_in_valid;
    logic                           r_in_opcode;
    logic [31:0]                    r_in_now_ms;
    logic                           r_in_raw_sensor;
    logic signed [POSITION_BITS-1:0] r_in_position;
    logic                           r_in_moving;
    logic                           r_out_valid;
    logic                           w_advance;
    logic                           w_in_take;
    logic                           w_out_faulted;
    logic                           w_out_not_vel;
    logic                           w_out_not_move;
    logic                           w_start_step;
    logic                           w_start_armed;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    shp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // handshake: step when the result slot is free or being emptied
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_opcode     <= i_opcode;
            r_in_now_ms     <= i_now_ms;
            r_in_raw_sensor <= i_raw_sensor;
            r_in_position   <= i_position;
            r_in_moving     <= i_moving;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // sequencer with state and result registers
    shp_seq #(
        .POSITION_BITS    (POSITION_BITS),
        .ARRIVE_TOLERANCE (ARRIVE_TOLERANCE)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_cfg        (w_cfg),
        .i_opcode     (r_in_opcode),
        .i_now_ms     (r_in_now_ms),
        .i_raw_sensor (r_in_raw_sensor),
        .i_position   (r_in_position),
        .i_moving     (r_in_moving),
        .o_move_kind  (o_move_kind),
        .o_velocity   (o_velocity),
        .o_target     (o_target),
        .o_phase      (o_phase),
        .o_fault_code (o_fault_code)
    );

    // conditions watched by the checks
    assign w_out_faulted  = o_out_valid && (o_fault_code != shp_pkg::FAULT_NONE);
    assign w_out_not_vel  = o_out_valid && (o_move_kind != shp_pkg::KIND_VELOCITY);
    assign w_out_not_move = o_out_valid && (o_move_kind != shp_pkg::KIND_MOVE_TO);
    assign w_start_step   = w_advance && (r_in_opcode == shp_pkg::OP_START);
    assign w_start_armed  = o_out_valid && (o_phase == shp_pkg::PHASE_CHECK)
                            && (o_fault_code == shp_pkg::FAULT_NONE)
                            && (o_move_kind == shp_pkg::KIND_STOP);

    // checks
    `ASSERT_IMPLY(a_fault_phase, i_clk, i_rst_n, w_out_faulted, o_phase == shp_pkg::PHASE_FAULT)
    `ASSERT_IMPLY(a_vel_only_velocity, i_clk, i_rst_n, w_out_not_vel, o_velocity == '0)
    `ASSERT_IMPLY(a_tgt_only_move_to, i_clk, i_rst_n, w_out_not_move, o_target == '0)
    `ASSERT_IMPLY(a_stall_needs_item, i_clk, i_rst_n, !r_in_valid, !o_in_stall)
    `ASSERT_NEXT(a_start_arms, i_clk, i_rst_n, w_start_step, w_start_armed)

endmodule

/* tb/tb_stepper_homing_sequencer_top.sv */
`timescale 1ns / 1ps

module tb_stepper_homing_sequencer_top;

    localparam int     POS_BITS       = shp_pkg::POSITION_BITS_DEF;
    localparam int     ARRIVE_TOL     = shp_pkg::ARRIVE_TOLERANCE_DEF;
    localparam longint POS_MAX        = (longint'(1) << (POS_BITS - 1)) - 1;
    localparam longint POS_MIN        = -(longint'(1) << (POS_BITS - 1));
    localparam int     NUM_SETTINGS   = 6;
    localparam int     TICKS_PER_SET  = 325;
    localparam int     LATENCY_CYCLES = 4;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_NS    = 2_000_000;
    // index beyond the register map, must be ignored
    localparam logic [3:0] CFG_NO_REGISTER = 4'hF;

    typedef enum logic [3:0] {
        HP_IDLE       = 4'd0,
        HP_CHECK      = 4'd1,
        HP_SEEK_FAST  = 4'd2,
        HP_BRAKE_FAST = 4'd3,
        HP_BACKOFF    = 4'd4,
        HP_SEEK_SLOW  = 4'd5,
        HP_BRAKE_SLOW = 4'd6,
        HP_SET_ZERO   = 4'd7,
        HP_TO_OFFSET  = 4'd8,
        HP_READY      = 4'd9,
        HP_FAULT      = 4'd10
    } t_homing_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [20:0] vel;
        logic signed [31:0] tgt;
        logic [3:0]         phase;
        logic [2:0]         fault;
    } t_homing_cmd;

    // tracks the homing sequence and holds the commands still to come
    class t_homing_tracker;
        shp_pkg::t_cfg cfg;
        t_homing_phase phase_q;
        logic [2:0]    fault_q;
        logic [31:0]   start_ms;
        longint        start_pos, trig1, backoff_tgt, trig2, rest_tgt;
        t_homing_cmd   pending_cmds[$];
        int            errors, checked, ready_count, fault_count;

        function new();
            cfg.seek_negative     = 1'b0;
            cfg.sensor_active_low = 1'b0;
            cfg.fast_speed        = shp_pkg::FAST_SPEED_RST;
            cfg.slow_speed        = shp_pkg::SLOW_SPEED_RST;
            cfg.search_limit      = shp_pkg::SEARCH_LIMIT_RST;
            cfg.backoff_distance  = shp_pkg::BACKOFF_DISTANCE_RST;
            cfg.rest_offset       = shp_pkg::REST_OFFSET_RST;
            cfg.timeout_ms        = shp_pkg::TIMEOUT_MS_RST;
            phase_q   = HP_IDLE;
            fault_q   = shp_pkg::FAULT_NONE;
            start_ms  = '0;
            start_pos = 0;
            trig1 = 0; backoff_tgt = 0; trig2 = 0; rest_tgt = 0;
            errors = 0; checked = 0; ready_count = 0; fault_count = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [31:0] data);
            case (idx)
                shp_pkg::CFG_SEEK_NEGATIVE:     cfg.seek_negative     = data[0];
                shp_pkg::CFG_SENSOR_ACTIVE_LOW: cfg.sensor_active_low = data[0];
                shp_pkg::CFG_FAST_SPEED:        cfg.fast_speed        = data[19:0];
                shp_pkg::CFG_SLOW_SPEED:        cfg.slow_speed        = data[19:0];
                shp_pkg::CFG_SEARCH_LIMIT:      cfg.search_limit      = data[29:0];
                shp_pkg::CFG_BACKOFF_DISTANCE:  cfg.backoff_distance  = data[23:0];
                shp_pkg::CFG_REST_OFFSET:       cfg.rest_offset       = data[23:0];
                shp_pkg::CFG_TIMEOUT_MS:        cfg.timeout_ms        = data;
                default: ;
            endcase
        endfunction

        function longint dist_of(longint a, longint b);
            return (a > b) ? a - b : b - a;
        endfunction

        function t_homing_cmd velocity_cmd(longint v);
            t_homing_cmd c;
            c = '0;
            c.kind = shp_pkg::KIND_VELOCITY;
            c.vel  = v[20:0];
            return c;
        endfunction

        function t_homing_cmd moveto_cmd(longint t);
            t_homing_cmd c;
            c = '0;
            c.kind = shp_pkg::KIND_MOVE_TO;
            c.tgt  = t[31:0];
            return c;
        endfunction

        function void enter_fault(logic [2:0] code);
            phase_q = HP_FAULT;
            fault_q = code;
            fault_count++;
        endfunction

        // advance the sequence by one accepted tick and queue its command
        function void note_tick(logic op, logic [31:0] now, logic raw,
                                logic signed [POS_BITS-1:0] pos_in, logic mov);
            t_homing_cmd c;
            logic        sensor, timed_out, over;
            logic [31:0] elapsed;
            longint      pos, dir, fast, slow, lim, back, rest;
            c       = '0;
            sensor  = raw ^ cfg.sensor_active_low;
            pos     = pos_in;
            dir     = cfg.seek_negative ? -1 : 1;
            fast    = cfg.fast_speed;
            slow    = cfg.slow_speed;
            lim     = cfg.search_limit;
            back    = cfg.backoff_distance;
            rest    = cfg.rest_offset;
            elapsed = now - start_ms;
            timed_out = elapsed > cfg.timeout_ms;
            over      = dist_of(pos, start_pos) > lim;
            if (op == shp_pkg::OP_START) begin
                phase_q   = HP_CHECK;
                fault_q   = shp_pkg::FAULT_NONE;
                start_ms  = now;
                start_pos = 0;
            end else begin
                case (phase_q)
                    HP_CHECK: begin
                        start_pos = pos;
                        if (sensor) enter_fault(shp_pkg::FAULT_SENSOR_START);
                        else begin
                            phase_q = HP_SEEK_FAST;
                            c = velocity_cmd(fast * dir);
                        end
                    end
                    HP_SEEK_FAST: begin
                        if (timed_out) enter_fault(shp_pkg::FAULT_TIMEOUT);
                        else if (over) enter_fault(shp_pkg::FAULT_OVERTRAVEL);
                        else if (sensor) begin
                            trig1   = pos;
                            phase_q = HP_BRAKE_FAST;
                        end else c = velocity_cmd(fast * dir);
                    end
                    HP_BRAKE_FAST: begin
                        if (timed_out) enter_fault(shp_pkg::FAULT_TIMEOUT);
                        else if (!mov) begin
                            backoff_tgt = trig1 - dir * back;
                            phase_q = HP_BACKOFF;
                            c = moveto_cmd(backoff_tgt);
                        end
                    end
                    HP_BACKOFF: begin
                        if (timed_out) enter_fault(shp_pkg::FAULT_TIMEOUT);
                        else if (dist_of(pos, backoff_tgt) < ARRIVE_TOL) begin
                            if (sensor) enter_fault(shp_pkg::FAULT_NOT_RELEASED);
                            else begin
                                phase_q = HP_SEEK_SLOW;
                                c = velocity_cmd(slow * dir);
                            end
                        end else c = moveto_cmd(backoff_tgt);
                    end
                    HP_SEEK_SLOW: begin
                        if (timed_out) enter_fault(shp_pkg::FAULT_TIMEOUT);
                        else if (over) enter_fault(shp_pkg::FAULT_NEVER_REACHED);
                        else if (sensor) begin
                            trig2   = pos;
                            phase_q = HP_BRAKE_SLOW;
                        end else c = velocity_cmd(slow * dir);
                    end
                    HP_BRAKE_SLOW: begin
                        if (timed_out) enter_fault(shp_pkg::FAULT_TIMEOUT);
                        else if (!mov) phase_q = HP_SET_ZERO;
                    end
                    HP_SET_ZERO: begin
                        rest_tgt = trig2 - dir * rest;
                        phase_q  = HP_TO_OFFSET;
                        c = moveto_cmd(rest_tgt);
                    end
                    HP_TO_OFFSET: begin
                        if (timed_out) enter_fault(shp_pkg::FAULT_TIMEOUT);
                        else if (dist_of(pos, rest_tgt) < ARRIVE_TOL) begin
                            phase_q = HP_READY;
                            ready_count++;
                        end else c = moveto_cmd(rest_tgt);
                    end
                    default: ;
                endcase
            end
            c.phase = phase_q;
            c.fault = fault_q;
            pending_cmds.push_back(c);
        endfunction

        // compare one command transfer against the oldest pending one
        function void check_command(t_homing_cmd got);
            t_homing_cmd want;
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t: command with nothing pending, kind %0d phase %0d",
                         $time, got.kind, got.phase);
                return;
            end
            want = pending_cmds.pop_front();
            checked++;
            if (got.kind !== want.kind) begin
                errors++;
                $display("%0t: move_kind expected %0d actual %0d", $time, want.kind, got.kind);
            end
            if (got.vel !== want.vel) begin
                errors++;
                $display("%0t: velocity expected %0d actual %0d", $time, want.vel, got.vel);
            end
            if (got.tgt !== want.tgt) begin
                errors++;
                $display("%0t: target expected %0d actual %0d", $time, want.tgt, got.tgt);
            end
            if (got.phase !== want.phase) begin
                errors++;
                $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
            end
            if (got.fault !== want.fault) begin
                errors++;
                $display("%0t: fault_code expected %0d actual %0d",
                         $time, want.fault, got.fault);
            end
        endfunction
    endclass

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_cfg_valid  = 1'b0;
    logic                       o_cfg_ready;
    logic [3:0]                 i_cfg_index  = '0;
    logic [31:0]                i_cfg_data   = '0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic                       i_opcode     = shp_pkg::OP_UPDATE;
    logic [31:0]                i_now_ms     = '0;
    logic                       i_raw_sensor = 1'b0;
    logic signed [POS_BITS-1:0] i_position   = '0;
    logic                       i_moving     = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    logic [1:0]                 o_move_kind;
    logic signed [20:0]         o_velocity;
    logic signed [31:0]         o_target;
    logic [3:0]                 o_phase;
    logic [2:0]                 o_fault_code;

    t_homing_tracker tracker = new();
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              tick_count    = 0;
    logic            hold_req      = 1'b0;
    logic [31:0]     clock_ms      = '0;
    longint          axis_pos      = 0;

    stepper_homing_sequencer_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_now_ms     (i_now_ms),
        .i_raw_sensor (i_raw_sensor),
        .i_position   (i_position),
        .i_moving     (i_moving),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_move_kind  (o_move_kind),
        .o_velocity   (o_velocity),
        .o_target     (o_target),
        .o_phase      (o_phase),
        .o_fault_code (o_fault_code)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check each transfer, then pick next stall
    always @(posedge i_clk) begin : result_side
        t_homing_cmd got;
        int          hold_left;
        logic        hold_taken;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind  = o_move_kind;
            got.vel   = o_velocity;
            got.tgt   = o_target;
            got.phase = o_phase;
            got.fault = o_fault_code;
            tracker.check_command(got);
        end
        if (hold_req && hold_taken !== 1'b1) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        i_out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // offer one tick and wait for its transfer
    task automatic send_tick(logic op, logic [31:0] now, logic raw, longint pos, logic mov);
        logic signed [POS_BITS-1:0] pv;
        pv = pos[POS_BITS-1:0];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_opcode     <= op;
        i_now_ms     <= now;
        i_raw_sensor <= raw;
        i_position   <= pv;
        i_moving     <= mov;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_tick(op, now, raw, pv, mov);
        tick_count++;
    endtask

    // stop offering until every pending command has come back
    task automatic drain(int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [3:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // register settings, extremes included
    task automatic program_setting(int which);
        logic [31:0] vals [8];
        case (which)
            0: vals = '{32'd0, 32'd0, 32'd30000, 32'd3000, 32'd200000, 32'd3000,
                        32'd1000, 32'd5000};
            1: vals = '{32'd1, 32'd1, $urandom_range(1000, 60000), $urandom_range(100, 6000),
                        $urandom_range(50000, 400000), $urandom_range(100, 5000),
                        $urandom_range(0, 5000), $urandom_range(2000, 20000)};
            2: vals = '{default: 32'hFFFF_FFFF};
            3: vals = '{default: 32'd0};
            4: foreach (vals[i]) vals[i] = $urandom;
            default: vals = '{32'd1, 32'd0, 32'h000F_FFFF, 32'd1, 32'd150000, 32'd2500,
                              32'd800, 32'd8000};
        endcase
        cfg_write(shp_pkg::CFG_SEEK_NEGATIVE, vals[0]);
        cfg_write(shp_pkg::CFG_SENSOR_ACTIVE_LOW, vals[1]);
        cfg_write(shp_pkg::CFG_FAST_SPEED, vals[2]);
        cfg_write(shp_pkg::CFG_SLOW_SPEED, vals[3]);
        cfg_write(shp_pkg::CFG_SEARCH_LIMIT, vals[4]);
        cfg_write(shp_pkg::CFG_BACKOFF_DISTANCE, vals[5]);
        cfg_write(shp_pkg::CFG_REST_OFFSET, vals[6]);
        cfg_write(shp_pkg::CFG_TIMEOUT_MS, vals[7]);
        if (which == 3) cfg_write(CFG_NO_REGISTER, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // hand-picked ticks under reset settings: every fault and the arrival edge
    task automatic directed_ticks();
        send_tick(shp_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, POS_MAX, 1'b1);
        send_tick(shp_pkg::OP_START, 32'd0, 1'b0, POS_MIN, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd1, 1'b1, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd2, 1'b0, 0, 1'b1);
        // first pass, then sensor still active after the back off
        send_tick(shp_pkg::OP_START, 32'd100, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd101, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd102, 1'b0, 1000, 1'b1);
        send_tick(shp_pkg::OP_UPDATE, 32'd103, 1'b1, 5000, 1'b1);
        send_tick(shp_pkg::OP_UPDATE, 32'd104, 1'b1, 5010, 1'b1);
        send_tick(shp_pkg::OP_UPDATE, 32'd105, 1'b1, 5012, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd106, 1'b1, 3000, 1'b1);
        send_tick(shp_pkg::OP_UPDATE, 32'd107, 1'b1, 2049, 1'b0);
        // arrival tolerance edge, then slow seek runs past the limit
        send_tick(shp_pkg::OP_START, 32'd200, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd201, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd202, 1'b1, 5000, 1'b1);
        send_tick(shp_pkg::OP_UPDATE, 32'd203, 1'b0, 5000, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd204, 1'b0, 2050, 1'b1);
        send_tick(shp_pkg::OP_UPDATE, 32'd205, 1'b0, 1951, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd206, 1'b0, 400000, 1'b1);
        // fast seek overtravel
        send_tick(shp_pkg::OP_START, 32'd300, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd301, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd302, 1'b0, 300001, 1'b1);
        // timeout across the time wrap
        send_tick(shp_pkg::OP_START, 32'hFFFF_FF00, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'hFFFF_FF00, 1'b0, 0, 1'b0);
        send_tick(shp_pkg::OP_UPDATE, 32'd29745, 1'b0, 100, 1'b1);
    endtask

    // step toward a target, landing inside or just outside tolerance at times
    function automatic longint approach(longint tgt, longint cur);
        int off;
        if ($urandom_range(0, 2) == 0) begin
            off = $urandom_range(0, 100);
            return tgt + off - 50;
        end
        return tgt + (cur - tgt) / 2;
    endfunction

    // mostly well formed motion that follows the tracked phase
    task automatic random_tick();
        logic   op, sens, mov;
        longint dir, lim;
        int     pick, off;
        dir  = tracker.cfg.seek_negative ? -1 : 1;
        lim  = tracker.cfg.search_limit;
        if ($urandom_range(0, 199) == 0) clock_ms += $urandom;
        else clock_ms += $urandom_range(0, 3);
        op   = shp_pkg::OP_UPDATE;
        sens = 1'b0;
        mov  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            // noise: every field random
            op = ($urandom_range(0, 7) == 0) ? shp_pkg::OP_START : shp_pkg::OP_UPDATE;
            send_tick(op, $urandom, 1'($urandom_range(0, 1)), longint'($urandom),
                      1'($urandom_range(0, 1)));
        end else begin
            if (pick < 5) op = shp_pkg::OP_START;
            else begin
                case (tracker.phase_q)
                    HP_CHECK: sens = ($urandom_range(0, 15) == 0);
                    HP_SEEK_FAST, HP_SEEK_SLOW: begin
                        off = $urandom_range(0, 3000);
                        axis_pos += dir * off;
                        if ($urandom_range(0, 59) == 0) begin
                            off = $urandom_range(0, 10);
                            axis_pos = tracker.start_pos + dir * (lim + off);
                        end
                        sens = ($urandom_range(0, 9) == 0);
                    end
                    HP_BRAKE_FAST, HP_BRAKE_SLOW: begin
                        off = $urandom_range(0, 50);
                        axis_pos += dir * off;
                        sens = ($urandom_range(0, 3) != 0);
                        mov  = ($urandom_range(0, 2) != 0);
                    end
                    HP_BACKOFF: begin
                        axis_pos = approach(tracker.backoff_tgt, axis_pos);
                        sens = ($urandom_range(0, 11) == 0);
                    end
                    HP_TO_OFFSET: begin
                        axis_pos = approach(tracker.rest_tgt, axis_pos);
                        sens = 1'($urandom_range(0, 1));
                    end
                    HP_SET_ZERO: sens = 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 7) != 0) begin
                            op  = shp_pkg::OP_START;
                            off = $urandom_range(0, 400000);
                            axis_pos = off - 200000;
                        end
                    end
                endcase
            end
            if (axis_pos > POS_MAX) axis_pos = POS_MAX;
            if (axis_pos < POS_MIN) axis_pos = POS_MIN;
            send_tick(op, clock_ms, sens ^ tracker.cfg.sensor_active_low, axis_pos, mov);
        end
    endtask

    // main stimulus
    initial begin
        send_idle_pct = 23;
        recv_idle_pct = 85;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_ticks();
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain(LATENCY_CYCLES);
            program_setting(s);
            if (s < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 85;
            end else if (s < 4) begin
                send_idle_pct = 85;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (s == 2) clock_ms = 32'hFFFF_F000;
            // long receiver hold while ticks keep coming
            if (s == 4) hold_req <= 1'b1;
            for (int n = 0; n < TICKS_PER_SET; n++) begin
                random_tick();
                if (n == TICKS_PER_SET / 2) drain(0);
            end
        end
        drain(LATENCY_CYCLES);
        $display("covered %0d ticks under %0d register settings, %0d commands compared",
                 tick_count, NUM_SETTINGS + 1, tracker.checked);
        $display("sequences reached ready %0d times and entered fault %0d times",
                 tracker.ready_count, tracker.fault_count);
        if (tracker.errors == 0 && tracker.pending_cmds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #WATCHDOG_NS;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/shp_pkg.sv
hdl/shp_cfg_regs.sv
hdl/shp_seq.sv
hdl/stepper_homing_sequencer_top.sv
tb/tb_stepper_homing_sequencer_top.sv
